[sv/vpp_pkg.sv]
// ----------------------------------------------------------------------------
// vpp_pkg: shared types and constants of the velocity profile planner
// Widths of the fixed-point datapath, arithmetic unit codes, sequencer states.
// ----------------------------------------------------------------------------
package vpp_pkg;

    localparam int SPEED_W = 20;   // Q10.10
    localparam int DIST_W  = 28;   // Q20.8
    localparam int CURV_W  = 20;   // Q4.16
    localparam int ACC_W   = 16;   // Q8.8
    localparam int PPM_W   = 20;   // Q12.8
    localparam int RAD_W   = 50;   // operand width of the shared unit
    localparam int ROOT_W  = 25;   // root of a RAD_W radicand
    localparam int REM_W   = 28;   // partial remainder of the shared unit
    localparam int VSQ_W   = 2 * SPEED_W;
    localparam int AD_W    = ACC_W + DIST_W;
    localparam int CNT_W   = 6;

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SHORT    = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef enum logic [2:0] {
        REG_BRAKE_ACCEL,
        REG_LATERAL_ACCEL,
        REG_POWER_PER_MASS,
        REG_INITIAL_SPEED,
        REG_FINAL_SPEED,
        REG_MIN_SPEED,
        REG_SPEED_CAP,
        REG_CURV_THRESH
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_L_CHK,
        S_L_DIV,
        S_L_SQRT,
        S_L_STORE,
        S_L_END,
        S_B_INIT,
        S_B_FIN,
        S_B_RD0,
        S_B_RD1,
        S_B_RD2,
        S_B_MUL,
        S_B_SQST,
        S_B_SQ,
        S_F_INIT,
        S_F_INIT2,
        S_F_RD0,
        S_F_RD1,
        S_F_RD2,
        S_F_DIV,
        S_F_MUL,
        S_F_SQST,
        S_F_SQ,
        S_O_RD,
        S_O_LOAD,
        S_O_WAIT
    } seq_state_t;

    // Clamp a root to the 20-bit speed range
    function automatic logic [SPEED_W-1:0] sat_speed(input logic [ROOT_W-1:0] r);
        logic [SPEED_W-1:0] s;
        s = (r > ROOT_W'(SPEED_MAX)) ? SPEED_MAX : r[SPEED_W-1:0];
        return s;
    endfunction

endpackage

[sv/vpp_arith.sv]
// ----------------------------------------------------------------------------
// vpp_arith: shared bit-serial divider and square root unit
// Restoring division (one quotient bit a cycle) or digit-by-digit
// floor square root (one root bit a cycle). done pulses in the cycle
// after the last step, with result valid in that cycle.
// ----------------------------------------------------------------------------
module vpp_arith
    import vpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  arith_req_t         req,
    input  logic [RAD_W-1:0]   opa,      // dividend or radicand
    input  logic [SPEED_W-1:0] opb,      // divisor
    output logic               done,
    output logic [RAD_W-1:0]   result
);

    logic               busy_reg;
    logic               done_reg;
    arith_op_t          op_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [RAD_W-1:0]   num_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [RAD_W-1:0]   res_reg;
    logic [SPEED_W-1:0] den_reg;

    logic [REM_W-1:0]   div_shift;
    logic [REM_W-1:0]   sq_shift;
    logic [REM_W-1:0]   sq_trial;
    logic               div_ge;
    logic               sq_ge;
    logic               last_step;

    // one step of each algorithm
    always_comb
    begin
        div_shift = {rem_reg[REM_W-2:0], num_reg[RAD_W-1]};
        div_ge    = div_shift >= REM_W'(den_reg);
        sq_shift  = {rem_reg[REM_W-3:0], num_reg[RAD_W-1 -: 2]};
        sq_trial  = {res_reg[REM_W-3:0], 2'b01};
        sq_ge     = sq_shift >= sq_trial;
        last_step = (op_reg == OP_DIV) ? (cnt_reg == CNT_W'(RAD_W - 1))
                                       : (cnt_reg == CNT_W'(ROOT_W - 1));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (req.start)
                busy_reg <= 1'b1;
            else if (busy_reg && last_step)
                busy_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            cnt_reg <= '0;
            num_reg <= opa;
            den_reg <= opb;
            rem_reg <= '0;
            res_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (op_reg == OP_DIV)
            begin
                num_reg <= {num_reg[RAD_W-2:0], 1'b0};
                rem_reg <= div_ge ? div_shift - REM_W'(den_reg) : div_shift;
                res_reg <= {res_reg[RAD_W-2:0], div_ge};
            end
            else
            begin
                num_reg <= {num_reg[RAD_W-3:0], 2'b00};
                rem_reg <= sq_ge ? sq_shift - sq_trial : sq_shift;
                res_reg <= {res_reg[RAD_W-2:0], sq_ge};
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[sv/velocity_profile_planner_top.sv]
// ----------------------------------------------------------------------------
// velocity_profile_planner_top: forward/backward lookahead speed planner
// Stores path points, then runs a braking pass and an acceleration pass over
// them with one shared divide/square-root unit, and streams the profile out.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one path point per transfer; tlast marks the final point
//   and starts the run. Points beyond MAX_POINTS are dropped and flag status 2.
//   Output stream: one transfer per stored point, index order, tlast on the
//   last one; a path of fewer than two points gives a single status-1 result.
//   APB port: eight registers at byte addresses 0..28, write while idle.
// Operation:
//   A point with curvature above the curvature threshold needs a 50-step divide
//   and a 25-step root in the shared unit. Each pass needs one root per segment;
//   the acceleration pass adds a power divide when power_per_mass is nonzero
//   and the earlier point's speed is above min_speed, and a segment whose
//   distance does not increase skips both. The shared unit's one bit per cycle
//   sets the run time. s_axis_tready is high only while waiting for a point.
// Reset: registers take their defaults, the point count and overflow flag
// clear; stored points are not cleared. A stalled receiver holds the current
// result and the sequencer waits.
// ----------------------------------------------------------------------------
module velocity_profile_planner_top
    import vpp_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input points
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // distance_along[27:0], curvature[47:28],
                                       // static_limit[67:48], zero[71:68]
    input  logic        s_axis_tlast,  // last_point
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // point_index[5:0], profile_speed[25:6],
                                       // limit_speed[45:26], status[47:46]
    output logic        m_axis_tlast,  // last_result
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // configuration registers
    logic [ACC_W-1:0]   brake_accel_reg;
    logic [ACC_W-1:0]   lateral_accel_reg;
    logic [PPM_W-1:0]   power_per_mass_reg;
    logic [SPEED_W-1:0] initial_speed_reg;
    logic [SPEED_W-1:0] final_speed_reg;
    logic [SPEED_W-1:0] min_speed_reg;
    logic [SPEED_W-1:0] speed_cap_reg;
    logic [CURV_W-1:0]  curv_thresh_reg;

    reg_idx_t ridx;
    assign ridx   = reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_accel_reg    <= ACC_W'(2512);
            lateral_accel_reg  <= ACC_W'(2512);
            power_per_mass_reg <= '0;
            initial_speed_reg  <= '0;
            final_speed_reg    <= '0;
            min_speed_reg      <= '0;
            speed_cap_reg      <= SPEED_MAX;
            curv_thresh_reg    <= CURV_W'(1);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                REG_BRAKE_ACCEL:    brake_accel_reg    <= pwdata[ACC_W-1:0];
                REG_LATERAL_ACCEL:  lateral_accel_reg  <= pwdata[ACC_W-1:0];
                REG_POWER_PER_MASS: power_per_mass_reg <= pwdata[PPM_W-1:0];
                REG_INITIAL_SPEED:  initial_speed_reg  <= pwdata[SPEED_W-1:0];
                REG_FINAL_SPEED:    final_speed_reg    <= pwdata[SPEED_W-1:0];
                REG_MIN_SPEED:      min_speed_reg      <= pwdata[SPEED_W-1:0];
                REG_SPEED_CAP:      speed_cap_reg      <= pwdata[SPEED_W-1:0];
                REG_CURV_THRESH:    curv_thresh_reg    <= pwdata[CURV_W-1:0];
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        unique case (ridx)
            REG_BRAKE_ACCEL:    prdata = 32'(brake_accel_reg);
            REG_LATERAL_ACCEL:  prdata = 32'(lateral_accel_reg);
            REG_POWER_PER_MASS: prdata = 32'(power_per_mass_reg);
            REG_INITIAL_SPEED:  prdata = 32'(initial_speed_reg);
            REG_FINAL_SPEED:    prdata = 32'(final_speed_reg);
            REG_MIN_SPEED:      prdata = 32'(min_speed_reg);
            REG_SPEED_CAP:      prdata = 32'(speed_cap_reg);
            REG_CURV_THRESH:    prdata = 32'(curv_thresh_reg);
        endcase
    end

    // sequencer and datapath registers
    seq_state_t         state_reg, state_next;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      count_reg;
    logic               ovf_reg;
    logic [DIST_W-1:0]  dist_in_reg;
    logic [CURV_W-1:0]  curv_in_reg;
    logic [SPEED_W-1:0] lim_reg;
    logic               last_in_reg;
    logic [DIST_W-1:0]  d_cur_reg;
    logic [DIST_W-1:0]  d_diff_reg;
    logic [SPEED_W-1:0] v_cur_reg;
    logic [SPEED_W-1:0] vp_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [VSQ_W-1:0]   vsq_reg;
    logic [AD_W-1:0]    ad_reg;
    logic               out_valid_reg;
    logic [5:0]         out_idx_reg;
    logic [SPEED_W-1:0] out_spd_reg;
    logic [SPEED_W-1:0] out_lim_reg;
    logic [1:0]         out_stat_reg;
    logic               out_last_reg;

    // point memories
    logic [DIST_W-1:0]  mem_dist [MAX_POINTS];
    logic [SPEED_W-1:0] mem_lim  [MAX_POINTS];
    logic [SPEED_W-1:0] mem_spd  [MAX_POINTS];
    logic [DIST_W-1:0]  dist_q;
    logic [SPEED_W-1:0] lim_q;
    logic [SPEED_W-1:0] spd_q;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic               we_pt;
    logic               we_spd;
    logic [SPEED_W-1:0] wspd;

    // shared unit hookup
    arith_req_t         req;
    logic [RAD_W-1:0]   opa;
    logic [SPEED_W-1:0] opb;
    logic               ar_done;
    logic [RAD_W-1:0]   ar_res;

    vpp_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .opa    (opa),
        .opb    (opb),
        .done   (ar_done),
        .result (ar_res)
    );

    logic               in_fire;
    logic               out_fire;
    logic [CW-1:0]      idx_m1;
    logic [SPEED_W-1:0] root_sat;
    logic [SPEED_W-1:0] lim_capped;
    logic [SPEED_W-1:0] fwd_v;
    logic [SPEED_W-1:0] init_v;
    logic               pwr_on;

    always_comb
    begin
        in_fire    = s_axis_tvalid && s_axis_tready;
        out_fire   = m_axis_tvalid && m_axis_tready;
        idx_m1     = idx_reg - 1'b1;
        root_sat   = sat_speed(ar_res[ROOT_W-1:0]);
        lim_capped = (lim_reg < speed_cap_reg) ? lim_reg : speed_cap_reg;
        fwd_v      = (v_cur_reg < root_sat) ? v_cur_reg : root_sat;
        if (fwd_v < min_speed_reg)
            fwd_v = min_speed_reg;
        init_v = spd_q;
        if (initial_speed_reg != '0 && initial_speed_reg < init_v)
            init_v = initial_speed_reg;
        if (init_v < min_speed_reg)
            init_v = min_speed_reg;
        pwr_on = (power_per_mass_reg != '0) && (spd_q > min_speed_reg);
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (we_pt)
        begin
            mem_dist[waddr] <= dist_in_reg;
            mem_lim[waddr]  <= lim_capped;
        end
        if (we_spd)
            mem_spd[waddr] <= wspd;
        dist_q <= mem_dist[raddr];
        lim_q  <= mem_lim[raddr];
        spd_q  <= mem_spd[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state, memory and unit controls
    always_comb
    begin
        state_next = state_reg;
        req        = '{start: 1'b0, op: OP_DIV};
        opa        = '0;
        opb        = '0;
        raddr      = idx_reg[AW-1:0];
        waddr      = idx_reg[AW-1:0];
        we_pt      = 1'b0;
        we_spd     = 1'b0;
        wspd       = lim_capped;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                    state_next = S_L_CHK;
            S_L_CHK:
            begin
                if (count_reg >= CW'(MAX_POINTS))
                    state_next = S_L_END;
                else if (curv_in_reg > curv_thresh_reg)
                begin
                    req        = '{start: 1'b1, op: OP_DIV};
                    opa        = RAD_W'({lateral_accel_reg, 28'b0});
                    opb        = curv_in_reg;
                    state_next = S_L_DIV;
                end
                else
                    state_next = S_L_STORE;
            end
            S_L_DIV:
                if (ar_done)
                begin
                    req        = '{start: 1'b1, op: OP_SQRT};
                    opa        = ar_res;
                    state_next = S_L_SQRT;
                end
            S_L_SQRT:
                if (ar_done)
                    state_next = S_L_STORE;
            S_L_STORE:
            begin
                waddr      = count_reg[AW-1:0];
                we_pt      = 1'b1;
                we_spd     = 1'b1;
                state_next = S_L_END;
            end
            S_L_END:
                if (!last_in_reg)
                    state_next = S_IDLE;
                else if (count_reg < CW'(2))
                    state_next = S_O_WAIT;
                else
                    state_next = (final_speed_reg != '0) ? S_B_INIT : S_B_RD0;
            S_B_INIT:
                state_next = S_B_FIN;
            S_B_FIN:
            begin
                we_spd     = 1'b1;
                wspd       = (lim_q < final_speed_reg) ? lim_q : final_speed_reg;
                state_next = S_B_RD0;
            end
            S_B_RD0:
                state_next = S_B_RD1;
            S_B_RD1:
            begin
                raddr      = idx_m1[AW-1:0];
                state_next = S_B_RD2;
            end
            S_B_RD2:
                if (d_cur_reg <= dist_q)
                    state_next = (idx_reg == CW'(1)) ? S_F_INIT : S_B_RD0;
                else
                    state_next = S_B_MUL;
            S_B_MUL:
                state_next = S_B_SQST;
            S_B_SQST:
            begin
                req        = '{start: 1'b1, op: OP_SQRT};
                opa        = RAD_W'(vsq_reg) + RAD_W'({ad_reg, 5'b0});
                state_next = S_B_SQ;
            end
            S_B_SQ:
                if (ar_done)
                begin
                    waddr      = idx_m1[AW-1:0];
                    we_spd     = 1'b1;
                    wspd       = (lim_reg < root_sat) ? lim_reg : root_sat;
                    state_next = (idx_reg == CW'(1)) ? S_F_INIT : S_B_RD0;
                end
            S_F_INIT:
                state_next = S_F_INIT2;
            S_F_INIT2:
            begin
                we_spd     = 1'b1;
                wspd       = init_v;
                state_next = S_F_RD0;
            end
            S_F_RD0:
                state_next = S_F_RD1;
            S_F_RD1:
            begin
                raddr      = idx_m1[AW-1:0];
                state_next = S_F_RD2;
            end
            S_F_RD2:
                if (d_cur_reg <= dist_q)
                    state_next = (idx_reg + 1'b1 == count_reg) ? S_O_RD : S_F_RD0;
                else if (pwr_on)
                begin
                    req        = '{start: 1'b1, op: OP_DIV};
                    opa        = RAD_W'({power_per_mass_reg, 10'b0});
                    opb        = spd_q;
                    state_next = S_F_DIV;
                end
                else
                    state_next = S_F_MUL;
            S_F_DIV:
                if (ar_done)
                    state_next = S_F_MUL;
            S_F_MUL:
                state_next = S_F_SQST;
            S_F_SQST:
            begin
                req        = '{start: 1'b1, op: OP_SQRT};
                opa        = RAD_W'(vsq_reg) + RAD_W'({ad_reg, 5'b0});
                state_next = S_F_SQ;
            end
            S_F_SQ:
                if (ar_done)
                begin
                    we_spd     = 1'b1;
                    wspd       = fwd_v;
                    state_next = (idx_reg + 1'b1 == count_reg) ? S_O_RD : S_F_RD0;
                end
            S_O_RD:
                state_next = S_O_LOAD;
            S_O_LOAD:
                state_next = S_O_WAIT;
            S_O_WAIT:
                if (out_fire)
                    state_next = out_last_reg ? S_IDLE : S_O_RD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control counters and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_L_CHK:
                    if (count_reg >= CW'(MAX_POINTS))
                        ovf_reg <= 1'b1;
                S_L_STORE:
                    count_reg <= count_reg + 1'b1;
                S_L_END:
                begin
                    idx_reg <= count_reg - 1'b1;
                    if (last_in_reg && count_reg < CW'(2))
                        out_valid_reg <= 1'b1;
                end
                S_B_RD2:
                    if (d_cur_reg <= dist_q)
                        idx_reg <= (idx_reg == CW'(1)) ? '0 : idx_m1;
                S_B_SQ:
                    if (ar_done)
                        idx_reg <= (idx_reg == CW'(1)) ? '0 : idx_m1;
                S_F_INIT2:
                    idx_reg <= CW'(1);
                S_F_RD2:
                    if (d_cur_reg <= dist_q)
                        idx_reg <= (idx_reg + 1'b1 == count_reg) ? '0 : idx_reg + 1'b1;
                S_F_SQ:
                    if (ar_done)
                        idx_reg <= (idx_reg + 1'b1 == count_reg) ? '0 : idx_reg + 1'b1;
                S_O_LOAD:
                    out_valid_reg <= 1'b1;
                S_O_WAIT:
                    if (out_fire)
                    begin
                        out_valid_reg <= 1'b0;
                        idx_reg       <= idx_reg + 1'b1;
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            idx_reg   <= '0;
                        end
                    end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    dist_in_reg <= s_axis_tdata[27:0];
                    curv_in_reg <= s_axis_tdata[47:28];
                    lim_reg     <= s_axis_tdata[67:48];
                    last_in_reg <= s_axis_tlast;
                end
            S_L_SQRT:
                if (ar_done && root_sat < lim_reg)
                    lim_reg <= root_sat;
            S_L_END:
            begin
                out_idx_reg  <= '0;
                out_spd_reg  <= '0;
                out_lim_reg  <= '0;
                out_stat_reg <= STAT_SHORT;
                out_last_reg <= 1'b1;
            end
            S_B_RD1, S_F_RD1:
            begin
                d_cur_reg <= dist_q;
                v_cur_reg <= spd_q;
            end
            S_B_RD2:
            begin
                d_diff_reg <= d_cur_reg - dist_q;
                lim_reg    <= lim_q;
                vp_reg     <= v_cur_reg;
                acc_reg    <= brake_accel_reg;
            end
            S_F_RD2:
            begin
                d_diff_reg <= d_cur_reg - dist_q;
                vp_reg     <= spd_q;
                acc_reg    <= lateral_accel_reg;
            end
            S_F_DIV:
                if (ar_done && ar_res < RAD_W'(acc_reg))
                    acc_reg <= ar_res[ACC_W-1:0];
            S_B_MUL, S_F_MUL:
            begin
                vsq_reg <= vp_reg * vp_reg;
                ad_reg  <= acc_reg * d_diff_reg;
            end
            S_O_LOAD:
            begin
                out_idx_reg  <= 6'(idx_reg);
                out_spd_reg  <= spd_q;
                out_lim_reg  <= lim_q;
                out_stat_reg <= ovf_reg ? STAT_OVERFLOW : STAT_OK;
                out_last_reg <= (idx_reg + 1'b1 == count_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_stat_reg, out_lim_reg, out_spd_reg, out_idx_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the velocity profile planner
// Streams paths of points into the planner, predicts the lateral/cap limits
// and the braking and acceleration passes in fixed point, and compares each
// result transfer field by field. Registers are reprogrammed before each pair of random paths.
// ----------------------------------------------------------------------------
module tb_top
    import vpp_pkg::*;
;

    localparam int NPTS      = 64;
    localparam int CYC_LIMIT = 4000000;

    typedef struct packed {
        logic [5:0]  idx;
        logic [19:0] prof;
        logic [19:0] lim;
        logic [1:0]  stat;
        logic        last;
    } result_t;

    typedef struct {
        logic [27:0] pos;
        logic [19:0] curv;
        logic [19:0] lim;
        logic        last;
        logic        has_exp;   // directed row carries a typed-in result
        result_t     exp_res;
    } point_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    velocity_profile_planner_top DUT (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // predictor state and register copies
    logic [15:0] cf_brake, cf_lat;
    logic [19:0] cf_ppm, cf_init, cf_final, cf_min, cf_cap, cf_mincurv;
    logic [27:0] pt_dist [NPTS];
    logic [19:0] pt_lim [NPTS];
    logic [19:0] pt_spd [NPTS];
    int          pt_count = 0;
    bit          pt_overflow = 0;

    result_t profile_q[$];
    int      errors = 0;
    int      cycles = 0;
    bit      hold_off = 0;
    bit      long_hold_req = 0;
    point_row_t directed[$];

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [19:0] clamp_speed(input logic [63:0] v);
        return (v > 64'hFFFFF) ? 20'hFFFFF : v[19:0];
    endfunction

    function automatic logic [19:0] reach_speed(input logic [63:0] v, input logic [63:0] a,
                                                input logic [63:0] d);
        return clamp_speed(floor_root(v * v + ((a * d) << 5)));
    endfunction

    function automatic logic [19:0] min20(input logic [19:0] a, input logic [19:0] b);
        return (a < b) ? a : b;
    endfunction

    // Queue expected results for one accepted point
    task automatic plan_point(input logic [27:0] pos, input logic [19:0] curv,
                              input logic [19:0] lim, input logic last);
        logic [19:0] l, vp, v;
        logic [63:0] a, d;
        result_t r;
        int n;
        if (pt_count < NPTS)
        begin
            l = lim;
            if (curv > cf_mincurv)
                l = min20(l, clamp_speed(floor_root((64'(cf_lat) << 28) / curv)));
            l = min20(l, cf_cap);
            pt_dist[pt_count] = pos;
            pt_lim[pt_count] = l;
            pt_spd[pt_count] = l;
            pt_count++;
        end
        else
            pt_overflow = 1;
        if (!last) return;
        n = pt_count;
        if (n < 2)
        begin
            r = '{idx: 0, prof: 0, lim: 0, stat: STAT_SHORT, last: 1};
            profile_q.insert(profile_q.size(), r);
        end
        else
        begin
            // braking pass
            if (cf_final > 0) pt_spd[n-1] = min20(pt_lim[n-1], cf_final);
            for (int i = n - 1; i > 0; i--)
            begin
                if (pt_dist[i] <= pt_dist[i-1]) continue;
                d = 64'(pt_dist[i] - pt_dist[i-1]);
                pt_spd[i-1] = min20(pt_lim[i-1],
                                    reach_speed(64'(pt_spd[i]), 64'(cf_brake), d));
            end
            // acceleration pass
            if (cf_init > 0) pt_spd[0] = min20(pt_spd[0], cf_init);
            if (pt_spd[0] < cf_min) pt_spd[0] = cf_min;
            for (int i = 1; i < n; i++)
            begin
                if (pt_dist[i] <= pt_dist[i-1]) continue;
                d = 64'(pt_dist[i] - pt_dist[i-1]);
                vp = pt_spd[i-1];
                a = 64'(cf_lat);
                if (cf_ppm != 0 && vp > cf_min)
                begin
                    if (((64'(cf_ppm) << 10) / vp) < a) a = (64'(cf_ppm) << 10) / vp;
                end
                v = min20(pt_spd[i], reach_speed(64'(vp), a, d));
                if (v < cf_min) v = cf_min;
                pt_spd[i] = v;
            end
            for (int i = 0; i < n; i++)
            begin
                r.idx = i[5:0];
                r.prof = pt_spd[i];
                r.lim = pt_lim[i];
                r.stat = pt_overflow ? STAT_OVERFLOW : STAT_OK;
                r.last = (i == n - 1);
                profile_q.insert(profile_q.size(), r);
            end
        end
        pt_count = 0;
        pt_overflow = 0;
    endtask

    // APB write, setup then access
    task automatic reg_write(input reg_idx_t ri, input logic [31:0] val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {ri, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (ri)
            REG_BRAKE_ACCEL:    cf_brake = val[15:0];
            REG_LATERAL_ACCEL:  cf_lat = val[15:0];
            REG_POWER_PER_MASS: cf_ppm = val[19:0];
            REG_INITIAL_SPEED:  cf_init = val[19:0];
            REG_FINAL_SPEED:    cf_final = val[19:0];
            REG_MIN_SPEED:      cf_min = val[19:0];
            REG_SPEED_CAP:      cf_cap = val[19:0];
            REG_CURV_THRESH:    cf_mincurv = val[19:0];
            default: ;
        endcase
    endtask

    // idle between points; with no gap the next point is offered at once
    task automatic sender_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) g = 0;
        if (g != 0)
        begin
            s_axis_tvalid <= 0;
            s_axis_tlast <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Offer one point and wait for its transfer
    task automatic send_point(input logic [27:0] pos, input logic [19:0] curv,
                              input logic [19:0] lim, input logic last);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {4'b0, lim, curv, pos};
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        plan_point(pos, curv, lim, last);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        s_axis_tlast <= 0;
        while (profile_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [19:0] rnd_speed();
        case ($urandom_range(0, 5))
            0: return 20'hFFFFF;
            1: return 20'd0;
            2: return 20'($urandom_range(0, 255));
            default: return 20'($urandom);
        endcase
    endfunction

    // random path: mostly increasing distances, some repeats and decreases
    task automatic send_path(input int n, input bit stall_mid);
        logic [27:0] pos;
        pos = 28'($urandom_range(0, 4095));
        for (int i = 0; i < n; i++)
        begin
            if (stall_mid && i == 2) long_hold_req = 1;
            case ($urandom_range(0, 9))
                0: ;
                1: pos = 28'($urandom);
                2: pos = pos + 28'($urandom);
                default: pos = pos + 28'($urandom_range(1, 8000));
            endcase
            send_point(pos, ($urandom_range(0, 2) == 0) ? 20'($urandom) :
                       20'($urandom_range(0, 64)), rnd_speed(), i == n - 1);
            sender_gap();
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (long_hold_req && !hold_off)
        begin
            hold_off = 1;
            long_hold_req = 0;
            m_axis_tready <= 0;
            repeat (3000) @(posedge clk);
            hold_off = 0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0) ||
                             ($urandom_range(0, 1) == 0 && $urandom_range(0, 1) == 0);
    end

    // result checker
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{idx: m_axis_tdata[5:0], prof: m_axis_tdata[25:6],
                    lim: m_axis_tdata[45:26], stat: m_axis_tdata[47:46],
                    last: m_axis_tlast};
            if (profile_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = profile_q.pop_front();
                if (got.idx !== want.idx || got.prof !== want.prof ||
                    got.lim !== want.lim || got.stat !== want.stat ||
                    got.last !== want.last)
                begin
                    $display("%0t: mismatch exp idx=%0d spd=%0d lim=%0d st=%0d last=%0d",
                             $time, want.idx, want.prof, want.lim, want.stat, want.last);
                    $display("%0t:          got idx=%0d spd=%0d lim=%0d st=%0d last=%0d",
                             $time, got.idx, got.prof, got.lim, got.stat, got.last);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic point_row_t mk(input logic [27:0] d, input logic [19:0] c,
                                      input logic [19:0] l, input logic t);
        point_row_t r;
        r.pos = d; r.curv = c; r.lim = l; r.last = t; r.has_exp = 0; r.exp_res = '0;
        return r;
    endfunction

    initial
    begin
        point_row_t row;
        cf_brake = 16'd2512; cf_lat = 16'd2512; cf_ppm = '0; cf_init = '0; cf_final = '0;
        cf_min = '0; cf_cap = 20'hFFFFF; cf_mincurv = 20'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table: short path, extremes, curvature, skipped segments
        row = mk(28'd100, 0, 20'd5000, 1);
        row.has_exp = 1;
        row.exp_res = '{idx: 0, prof: 0, lim: 0, stat: STAT_SHORT, last: 1};
        directed.insert(directed.size(), row);
        directed.insert(directed.size(), mk(0, 0, 20'hFFFFF, 0));
        directed.insert(directed.size(), mk(28'hFFFFFFF, 20'hFFFFF, 20'hFFFFF, 0));
        directed.insert(directed.size(), mk(28'hFFFFFFF, 20'd2, 0, 0));
        directed.insert(directed.size(), mk(28'd10, 20'd1, 20'd3000, 0));
        directed.insert(directed.size(), mk(28'd20000, 20'd600, 20'h80000, 1));
        directed.insert(directed.size(), mk(28'd0, 20'd0, 20'd1024, 0));
        directed.insert(directed.size(), mk(28'd256, 20'd0, 20'd20480, 0));
        directed.insert(directed.size(), mk(28'd512, 20'h00400, 20'd30000, 0));
        directed.insert(directed.size(), mk(28'd1024, 20'd0, 20'd10, 1));
        foreach (directed[k])
        begin
            if (directed[k].has_exp)
                profile_q.insert(profile_q.size(), directed[k].exp_res);
            send_point(directed[k].pos, directed[k].curv, directed[k].lim, directed[k].last);
            if (directed[k].has_exp)
                void'(profile_q.pop_back());  // predictor adds the same row
            sender_gap();
        end
        drain();

        // overflow: 66 points
        send_path(66, 0);
        drain();

        // sweep register settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    reg_write(REG_BRAKE_ACCEL, 32'hFFFF);
                    reg_write(REG_LATERAL_ACCEL, 32'hFFFF);
                    reg_write(REG_POWER_PER_MASS, 32'hFFFFF);
                    reg_write(REG_INITIAL_SPEED, 32'hFFFFF);
                    reg_write(REG_FINAL_SPEED, 32'hFFFFF);
                    reg_write(REG_MIN_SPEED, 32'hFFFFF);
                    reg_write(REG_SPEED_CAP, 32'hFFFFF);
                    reg_write(REG_CURV_THRESH, 32'hFFFFF);
                end
                1:
                begin
                    reg_write(REG_BRAKE_ACCEL, 0);
                    reg_write(REG_LATERAL_ACCEL, 0);
                    reg_write(REG_POWER_PER_MASS, 0);
                    reg_write(REG_INITIAL_SPEED, 0);
                    reg_write(REG_FINAL_SPEED, 0);
                    reg_write(REG_MIN_SPEED, 0);
                    reg_write(REG_SPEED_CAP, 0);
                    reg_write(REG_CURV_THRESH, 0);
                end
                default:
                begin
                    reg_write(REG_BRAKE_ACCEL, $urandom_range(0, 4000));
                    reg_write(REG_LATERAL_ACCEL, $urandom & 32'hFFFF);
                    reg_write(REG_POWER_PER_MASS, $urandom_range(0, 1) ? $urandom_range(1, 60000)
                                                                        : $urandom);
                    reg_write(REG_INITIAL_SPEED, $urandom_range(0, 1) ? 0 : $urandom_range(1, 40000));
                    reg_write(REG_FINAL_SPEED, $urandom_range(0, 1) ? 0 : $urandom_range(1, 40000));
                    reg_write(REG_MIN_SPEED, $urandom_range(0, 1) ? 0 : $urandom_range(0, 5000));
                    reg_write(REG_SPEED_CAP, $urandom_range(0, 1) ? 20'hFFFFF : $urandom);
                    reg_write(REG_CURV_THRESH, $urandom_range(0, 1) ? $urandom_range(0, 8)
                                                                    : $urandom);
                end
            endcase
            // the first path of phase 2 holds off the receiver while the next is offered
            for (int p = 0; p < 2; p++)
            begin
                int len;
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 5);
                if (ph == 2 && p == 0) len = 5;
                send_path(len, ph == 2 && p == 0);
            end
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
